### design/fefd_pkg.sv
// Shared types and constants for the flag/escape frame decoder.
package fefd_pkg;

    localparam int          MAX_FRAME_LIMIT_DEF = 2047;
    localparam int          LEN_W               = 11;
    localparam logic [7:0]  FLAG_BYTE           = 8'h7e;
    localparam logic [7:0]  ESC_BYTE            = 8'h7d;
    localparam logic [LEN_W-1:0] MAX_FRAME_RST  = 11'd1500;

    typedef enum logic {
        REG_ENABLE    = 1'b0,
        REG_MAX_FRAME = 1'b1
    } reg_idx_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } out_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_error;
    } in_beat_t;

    typedef struct packed {
        logic            truncated;
        logic [LEN_W-1:0] frame_length;
        logic [LEN_W-1:0] out_offset;
        logic [7:0]      out_byte;
    } out_data_t;

endpackage

### design/fefd_in_stage.sv
// Input register stage holding one received line beat.
module fefd_in_stage
    import fefd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_beat_t s_beat,
    input  logic     take,
    output logic     beat_valid,
    output in_beat_t beat
);

    logic     valid_reg, valid_next;
    in_beat_t beat_reg;

    assign s_tready   = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg <= s_beat;
        end
    end

endmodule

### design/fefd_core.sv
// Deframing state, configuration registers and result register.
module fefd_core
    import fefd_pkg::*;
#(
    parameter int MAX_FRAME_LIMIT = MAX_FRAME_LIMIT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [LEN_W-1:0] cfg_wdata,
    input  logic             beat_valid,
    input  in_beat_t         beat,
    output logic             take,
    output logic             m_tvalid,
    input  logic             m_tready,
    output out_kind_t        m_kind,
    output out_data_t        m_data,
    output logic [LEN_W-1:0] limit
);

    localparam logic [LEN_W-1:0] LIM_CAP =
        (MAX_FRAME_LIMIT >= (1 << LEN_W) - 1) ? {LEN_W{1'b1}} : LEN_W'(MAX_FRAME_LIMIT);

    typedef enum logic [2:0] {
        SYM_NONE = 3'b001,
        SYM_FLAG = 3'b010,
        SYM_ESC  = 3'b100
    } sym_t;

    logic             enable_reg;
    logic [LEN_W-1:0] max_frame_reg;
    logic             hunting_reg, hunting_next;
    sym_t             sym_reg, sym_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             valid_reg, valid_next;
    out_kind_t        kind_reg, kind_next;
    out_data_t        data_reg, data_next;
    logic             res_valid, do_store, out_free;
    logic [LEN_W-1:0] lim_capped;

    assign out_free   = !valid_reg || m_tready;
    assign take       = beat_valid && out_free;
    assign m_tvalid   = valid_reg;
    assign m_kind     = kind_reg;
    assign m_data     = data_reg;
    assign lim_capped = (max_frame_reg > LIM_CAP) ? LIM_CAP : max_frame_reg;
    assign limit      = (lim_capped == '0) ? LEN_W'(1) : lim_capped;

    always_comb begin
        hunting_next = hunting_reg;
        sym_next     = sym_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        res_valid    = 1'b0;
        do_store     = 1'b0;
        kind_next    = KIND_PAYLOAD;
        data_next    = '0;
        if (take && enable_reg && !beat.rx_error) begin
            if (hunting_reg) begin
                if (beat.rx_byte == FLAG_BYTE) begin
                    hunting_next = 1'b0;
                    sym_next     = SYM_FLAG;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                end
            end else if (sym_reg == SYM_ESC) begin
                sym_next = SYM_NONE;
                do_store = 1'b1;
            end else if (beat.rx_byte == ESC_BYTE) begin
                sym_next = SYM_ESC;
            end else if (beat.rx_byte == FLAG_BYTE) begin
                sym_next = SYM_FLAG;
                if (count_reg != '0) begin
                    res_valid              = 1'b1;
                    kind_next              = KIND_END;
                    data_next.frame_length = count_reg;
                    data_next.truncated    = ovf_reg;
                end
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                sym_next = SYM_NONE;
                do_store = 1'b1;
            end
            if (do_store) begin
                if (count_reg < limit) begin
                    res_valid            = 1'b1;
                    data_next.out_byte   = beat.rx_byte;
                    data_next.out_offset = count_reg;
                    count_next           = count_reg + LEN_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = res_valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            max_frame_reg <= MAX_FRAME_RST;
            hunting_reg   <= 1'b1;
            sym_reg       <= SYM_NONE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_addr))
                    REG_ENABLE:    enable_reg    <= cfg_wdata[0];
                    REG_MAX_FRAME: max_frame_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            hunting_reg <= hunting_next;
            sym_reg     <= sym_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg <= kind_next;
            data_reg <= data_next;
        end
    end

endmodule

### design/flag_escape_frame_decoder.sv
// Top level of the flag/escape frame decoder.
// Removes byte-stuffed framing from a received byte stream: 0x7e delimits frames,
// 0x7d makes the next byte literal (no XOR). After reset the decoder discards
// bytes until the first flag. Each stored payload byte leaves as one beat with
// its offset; a flag closing a non-empty frame leaves one end beat with the
// stored length and a truncation mark for bytes dropped past max_frame (capped
// at MAX_FRAME_LIMIT, zero taken as one). Bytes with s_tuser set or received
// while disabled are dropped. One byte is taken every cycle unless a result beat
// is held by m_tready low: an input register and a result register bracket a
// single pass of decode logic.
module flag_escape_frame_decoder
    import fefd_pkg::*;
#(
    parameter int MAX_FRAME_LIMIT = MAX_FRAME_LIMIT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [LEN_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] rx_byte
    input  logic             s_tuser,   // [0] rx_error
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // [7:0] out_byte, [18:8] out_offset,
                                        // [29:19] frame_length, [30] truncated
    output logic             m_tuser    // [0] out_kind
);

    in_beat_t         s_beat, beat;
    logic             beat_valid, take;
    out_kind_t        m_kind;
    out_data_t        m_data;
    logic [LEN_W-1:0] limit;

    assign s_beat.rx_byte  = s_tdata;
    assign s_beat.rx_error = s_tuser;
    assign m_tdata         = {1'b0, m_data};
    assign m_tuser         = m_kind;

    fefd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    fefd_core #(
        .MAX_FRAME_LIMIT (MAX_FRAME_LIMIT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .beat_valid (beat_valid),
        .beat       (beat),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_kind     (m_kind),
        .m_data     (m_data),
        .limit      (limit)
    );

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_kind == KIND_PAYLOAD |-> m_data.frame_length == '0 && !m_data.truncated)
        else $error("payload beat carries frame-end fields");

    a_end_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_kind == KIND_END |-> m_data.frame_length != '0 && m_data.out_byte == '0)
        else $error("frame end with zero length or nonzero byte");

    a_offset_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_kind == KIND_PAYLOAD |-> m_data.out_offset < limit)
        else $error("payload offset beyond frame limit");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

endmodule

### tb/sv/flag_escape_frame_decoder_tb.sv
// Self-checking testbench for the flag/escape frame decoder: directed table, random frames.
module flag_escape_frame_decoder_tb;
    import fefd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int N_OFF_ROWS = 2;
    localparam int N_ROWS     = 27;

    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_TYPED
    } row_chk_t;

    typedef struct packed {
        out_kind_t kind;
        out_data_t d;
    } frame_res_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       err;
        row_chk_t   chk;
        frame_res_t res;
    } dir_row_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    reg_idx_t         cfg_addr  = REG_ENABLE;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;
    logic             m_tuser;

    // decoder state as predicted
    logic             en_q   = 1'b0;
    logic [LEN_W-1:0] mf_q   = MAX_FRAME_RST;
    logic             hunt_q = 1'b1;
    logic             esc_q  = 1'b0;
    logic [LEN_W-1:0] cnt_q  = '0;
    logic             ovf_q  = 1'b0;

    frame_res_t res_q[$];
    dir_row_t   dir_tbl[N_ROWS];
    int         n_err          = 0;
    int         n_items        = 0;
    int         burst_left     = 0;
    int         idle_cyc       = 0;
    int         rcv_cyc        = 0;
    int         stall_cnt      = 0;
    bit         long_stall_req = 1'b0;
    bit         long_stall_done = 1'b0;

    flag_escape_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic bit decode_byte(input logic [7:0] b, input logic e,
                                       output frame_res_t r);
        int  lim;
        bit  has;
        r = '0;
        if (!en_q || e)
            return 1'b0;
        if (hunt_q) begin
            if (b == FLAG_BYTE) begin
                hunt_q = 1'b0;
                esc_q  = 1'b0;
                cnt_q  = '0;
                ovf_q  = 1'b0;
            end
            return 1'b0;
        end
        if (!esc_q && b == ESC_BYTE) begin
            esc_q = 1'b1;
            return 1'b0;
        end
        if (!esc_q && b == FLAG_BYTE) begin
            r.kind           = KIND_END;
            r.d.frame_length = cnt_q;
            r.d.truncated    = ovf_q;
            has              = (cnt_q != 0);
            cnt_q            = '0;
            ovf_q            = 1'b0;
            return has;
        end
        esc_q = 1'b0;
        lim   = (int'(mf_q) > MAX_FRAME_LIMIT_DEF) ? MAX_FRAME_LIMIT_DEF : int'(mf_q);
        if (lim == 0)
            lim = 1;
        if (int'(cnt_q) < lim) begin
            r.kind         = KIND_PAYLOAD;
            r.d.out_byte   = b;
            r.d.out_offset = cnt_q;
            cnt_q          = cnt_q + 1'b1;
            return 1'b1;
        end
        ovf_q = 1'b1;
        return 1'b0;
    endfunction

    function automatic dir_row_t mk_row(input logic [7:0] rx, input logic err,
                                        input row_chk_t chk, input out_kind_t kind,
                                        input logic [7:0] ob, input int off,
                                        input int len, input logic tr);
        dir_row_t row;
        row.rx                 = rx;
        row.err                = err;
        row.chk                = chk;
        row.res.kind           = kind;
        row.res.d.out_byte     = ob;
        row.res.d.out_offset   = off[LEN_W-1:0];
        row.res.d.frame_length = len[LEN_W-1:0];
        row.res.d.truncated    = tr;
        return row;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic e, input row_chk_t chk,
                             input frame_res_t typed);
        frame_res_t r;
        bit         has;
        int         gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                @(negedge aclk) s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= e;
        do @(posedge aclk); while (!s_tready);
        if (en_q && !e)
            n_items++;
        has = decode_byte(b, e, r);
        if (chk == CHK_TYPED)
            res_q.push_back(typed);
        else if (chk == CHK_PRED && has)
            res_q.push_back(r);
    endtask

    task automatic send_frame(input int len, input bit clean);
        logic [7:0] b;
        int         k;
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0:       b = FLAG_BYTE;
                1:       b = ESC_BYTE;
                default: b = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b1, CHK_PRED, '0);
            // drop the stuffing now and then to break the frame
            if ((b == FLAG_BYTE || b == ESC_BYTE) && (clean || $urandom_range(0, 19) != 0))
                send_item(ESC_BYTE, 1'b0, CHK_PRED, '0);
            send_item(b, 1'b0, CHK_PRED, '0);
        end
        if (!clean && $urandom_range(0, 15) == 0)
            send_item(ESC_BYTE, 1'b0, CHK_PRED, '0);
        send_item(FLAG_BYTE, 1'b0, CHK_PRED, '0);
    endtask

    task automatic wait_idle();
        @(negedge aclk) s_tvalid <= 1'b0;
        burst_left = 0;
        while (res_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [LEN_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_ENABLE:    en_q = val[0];
            REG_MAX_FRAME: mf_q = val;
            default: begin
            end
        endcase
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // receiver: rotating ready patterns plus one long hold-off
    always @(negedge aclk) begin
        rcv_cyc++;
        if (long_stall_req && !long_stall_done) begin
            long_stall_done = 1'b1;
            stall_cnt       = 300;
        end
        if (stall_cnt > 0) begin
            stall_cnt--;
            m_tready <= 1'b0;
        end else begin
            case ((rcv_cyc / 97) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ((rcv_cyc % 5) != 0);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin : chk_out
        frame_res_t want;
        out_data_t  got;
        if (aresetn && m_tvalid && m_tready) begin
            got = out_data_t'(m_tdata[30:0]);
            if (res_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected beat: kind %0d tdata %h", m_tuser, m_tdata);
            end else begin
                want = res_q.pop_front();
                if (m_tuser !== want.kind || got.out_byte !== want.d.out_byte
                        || got.out_offset !== want.d.out_offset
                        || got.frame_length !== want.d.frame_length
                        || got.truncated !== want.d.truncated || m_tdata[31] !== 1'b0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display({"mismatch: exp kind %0d byte %h off %0d len %0d trunc %0d",
                                  " / got kind %0d byte %h off %0d len %0d trunc %0d pad %b"},
                                 want.kind, want.d.out_byte, want.d.out_offset,
                                 want.d.frame_length, want.d.truncated, m_tuser,
                                 got.out_byte, got.out_offset, got.frame_length,
                                 got.truncated, m_tdata[31]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stim
        int               k;
        int               phase;
        int               start;
        int               len;
        int               mf;
        int               mf_plan[7];
        mf_plan = '{1, 2, 7, 2047, 0, 1500, 0};

        dir_tbl[0]  = mk_row(8'h7e, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[1]  = mk_row(8'h41, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[2]  = mk_row(8'h00, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[3]  = mk_row(8'h7e, 1'b1, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[4]  = mk_row(8'hff, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[5]  = mk_row(8'h7d, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[6]  = mk_row(8'h7e, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[7]  = mk_row(8'h7e, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[8]  = mk_row(8'h00, 1'b0, CHK_TYPED, KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[9]  = mk_row(8'h7d, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[10] = mk_row(8'h7e, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[11] = mk_row(8'h7d, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[12] = mk_row(8'h7d, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[13] = mk_row(8'hff, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[14] = mk_row(8'h55, 1'b1, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[15] = mk_row(8'h7e, 1'b0, CHK_TYPED, KIND_END,     8'h00, 0, 3, 1'b1);
        dir_tbl[16] = mk_row(8'hff, 1'b0, CHK_TYPED, KIND_PAYLOAD, 8'hff, 0, 0, 1'b0);
        dir_tbl[17] = mk_row(8'h7d, 1'b1, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[18] = mk_row(8'h7e, 1'b0, CHK_TYPED, KIND_END,     8'h00, 0, 1, 1'b0);
        dir_tbl[19] = mk_row(8'h7d, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[20] = mk_row(8'h7e, 1'b1, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[21] = mk_row(8'h7e, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[22] = mk_row(8'h80, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[23] = mk_row(8'h01, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[24] = mk_row(8'h7d, 1'b0, CHK_PRED,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[25] = mk_row(8'h7e, 1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00, 0, 0, 1'b0);
        dir_tbl[26] = mk_row(8'h7e, 1'b0, CHK_TYPED, KIND_END,     8'h00, 0, 3, 1'b1);

        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        for (k = 0; k < N_ROWS; k++) begin
            if (k == N_OFF_ROWS) begin
                wait_idle();
                cfg_write(REG_ENABLE, LEN_W'(1));
                cfg_write(REG_MAX_FRAME, LEN_W'(3));
            end
            send_item(dir_tbl[k].rx, dir_tbl[k].err, dir_tbl[k].chk, dir_tbl[k].res);
        end

        for (phase = 0; phase < 7; phase++) begin
            mf = (mf_plan[phase] == 0) ? $urandom_range(2, 64) : mf_plan[phase];
            wait_idle();
            cfg_write(REG_MAX_FRAME, mf[LEN_W-1:0]);
            if (phase == 2) begin
                cfg_write(REG_ENABLE, LEN_W'(0));
                repeat (3) send_frame(6, 1'b0);
                wait_idle();
                cfg_write(REG_ENABLE, LEN_W'(1));
            end
            if (mf == 1500)
                long_stall_req = 1'b1;
            start = n_items;
            while (n_items - start < 115) begin
                if ($urandom_range(0, 7) == 0)
                    len = mf + $urandom_range(0, 4);
                else
                    len = $urandom_range(0, 12);
                if (len > 70)
                    len = $urandom_range(0, 12);
                send_frame(len, 1'b0);
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (n_err == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
